>>> rtl/wcv_pkg.sv
// shared constants, payload structs and control types of the window convolution block
package wcv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 7;
    localparam int PIXEL_BITS = 12;
    localparam int COEF_BITS  = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int NUM_TAPS  = MAX_KERNEL * MAX_KERNEL;
    localparam int KERN_TOP  = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int EH_W      = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W    = $clog2(MAX_KERNEL);
    localparam int K_W       = $clog2(MAX_KERNEL + 1);
    localparam int STEP_W    = $clog2(MAX_KERNEL + 4);
    localparam int TAP_AW    = $clog2(NUM_TAPS);
    localparam int PROD_W    = PIXEL_BITS + COEF_BITS;
    localparam int ACC_W     = PROD_W + $clog2(NUM_TAPS);
    localparam int FRAC_BITS = COEF_BITS - 2;
    localparam int PEND_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_WID_W = 11;
    localparam int CFG_HGT_W = 13;
    localparam int CFG_KER_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

    // item kinds
    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [5:0]                  coef_index;
        logic signed [COEF_BITS-1:0] coef_value;
        logic signed [PIXEL_BITS-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] result_pixel;
        logic [11:0]                  out_row;
        logic [9:0]                   out_col;
        logic                         out_last;
    } out_item_t;

    // control bundle broadcast to every cell
    typedef struct packed {
        logic                  pix_we;
        logic [SLOT_W-1:0]     wslot;
        logic [COL_W-1:0]      pix_waddr;
        logic [PIXEL_BITS-1:0] pix_wdata;
        logic                  tap_we;
        logic [TAP_AW-1:0]     tap_waddr;
        logic [COEF_BITS-1:0]  tap_wdata;
        logic                  pix_re;
        logic                  issue;
        logic [COL_W-1:0]      pix_raddr;
        logic [K_W-1:0]        col_j;
        logic [SLOT_W-1:0]     base;
        logic [K_W-1:0]        ksize;
        logic                  acc_clr;
        logic                  chain_en;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_CALC,
        ST_CHAIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/window_convolution_2d.sv
// top level: stream control, counters and the row of convolution cells
// result path: an item with no result leaves the block idle; a border pixel result is read
// from its line store slot and then loaded into the output register; an interior result
// goes through a k-step tap sweep across the cell row, then the 7-stage partial-sum chain
// input: one item at a time; the next is taken once idle, after any result is loaded out
// reset: asynchronous active low; taps read as zero until written, line stores not cleared
module window_convolution_2d (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  wcv_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wcv_pkg::out_item_t                out_data,
    input  logic                              cfg_write,
    input  logic [wcv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic signed [wcv_pkg::ACC_W-1:0] RND_HALF =
        {{(wcv_pkg::ACC_W - wcv_pkg::FRAC_BITS){1'b0}}, 1'b1,
         {(wcv_pkg::FRAC_BITS - 1){1'b0}}};
    localparam logic signed [wcv_pkg::ACC_W-1:0] PIX_MAX =
        {{(wcv_pkg::ACC_W - wcv_pkg::PIXEL_BITS + 1){1'b0}},
         {(wcv_pkg::PIXEL_BITS - 1){1'b1}}};
    localparam logic signed [wcv_pkg::ACC_W-1:0] PIX_MIN =
        {{(wcv_pkg::ACC_W - wcv_pkg::PIXEL_BITS + 1){1'b1}},
         {(wcv_pkg::PIXEL_BITS - 1){1'b0}}};

    wcv_pkg::state_t state_reg, state_next;

    logic [wcv_pkg::CFG_WID_W-1:0] width_reg;
    logic [wcv_pkg::CFG_HGT_W-1:0] height_reg;
    logic [wcv_pkg::CFG_KER_W-1:0] ksize_reg;

    logic [wcv_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [wcv_pkg::ROW_W-1:0]  in_row_reg, in_row_next;
    logic [wcv_pkg::SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [wcv_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [wcv_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [wcv_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [wcv_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic                       drain_reg, drain_next;
    logic [wcv_pkg::NUM_TAPS-1:0] tap_valid_reg;
    logic [wcv_pkg::STEP_W-1:0] step_reg;

    logic [wcv_pkg::COL_W-1:0]  em_col_reg;
    logic [wcv_pkg::ROW_W-1:0]  em_row_reg;
    logic [wcv_pkg::SLOT_W-1:0] em_slot_reg;
    logic [wcv_pkg::SLOT_W-1:0] em_base_reg;
    logic                       em_win_reg;
    logic                       em_last_reg;

    logic                       out_valid_reg;
    wcv_pkg::out_item_t         out_data_reg;

    logic [wcv_pkg::EW_W-1:0]   eff_w;
    logic [wcv_pkg::EH_W-1:0]   eff_h;
    logic [wcv_pkg::K_W-1:0]    eff_k;
    logic [wcv_pkg::K_W-1:0]    half;
    logic [wcv_pkg::PEND_W-1:0] lag;

    logic                       accept;
    logic                       is_pix, is_flush, is_coef, origin_clr, emit;
    logic [wcv_pkg::EW_W-1:0]   icol_inc, ocol_inc;
    logic [wcv_pkg::EH_W-1:0]   irow_inc, orow_inc;
    logic                       icol_wrap, irow_wrap, ocol_wrap, orow_wrap;
    logic [wcv_pkg::COL_W-1:0]  em_col_c;
    logic [wcv_pkg::ROW_W-1:0]  em_row_c;
    logic [wcv_pkg::SLOT_W-1:0] em_slot_c;
    logic [wcv_pkg::SLOT_W-1:0] em_base_c;
    logic [wcv_pkg::SLOT_W:0]   base_sum;
    logic [wcv_pkg::PEND_W-1:0] pend_base;
    logic                       win_c, last_c;
    logic                       load_out;

    wcv_pkg::cell_ctrl_t        ctrl;
    logic signed [wcv_pkg::ACC_W-1:0]      chain_w [wcv_pkg::MAX_KERNEL];
    logic signed [wcv_pkg::PIXEL_BITS-1:0] pix_w [wcv_pkg::MAX_KERNEL];
    logic signed [wcv_pkg::ACC_W-1:0]      rnd_sum, shifted, sat_val;
    logic signed [wcv_pkg::PIXEL_BITS-1:0] result_c;

    // effective geometry from the configuration registers
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = wcv_pkg::EW_W'(1);
        end
        else if (int'(width_reg) > wcv_pkg::MAX_WIDTH)
        begin
            eff_w = wcv_pkg::EW_W'(wcv_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = wcv_pkg::EW_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            eff_h = wcv_pkg::EH_W'(1);
        end
        else if (int'(height_reg) > wcv_pkg::MAX_HEIGHT)
        begin
            eff_h = wcv_pkg::EH_W'(wcv_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = wcv_pkg::EH_W'(height_reg);
        end
        eff_k = wcv_pkg::K_W'(ksize_reg);
        if (eff_k == '0)
        begin
            eff_k = wcv_pkg::K_W'(1);
        end
        if (!eff_k[0])
        begin
            eff_k = eff_k - wcv_pkg::K_W'(1);
        end
        if (int'(eff_k) > wcv_pkg::KERN_TOP)
        begin
            eff_k = wcv_pkg::K_W'(wcv_pkg::KERN_TOP);
        end
        half = eff_k >> 1;
        lag  = wcv_pkg::PEND_W'(half) * wcv_pkg::PEND_W'(eff_w) + wcv_pkg::PEND_W'(half);
    end

    // transaction decode
    assign accept   = in_valid && in_ready;
    assign is_pix   = accept && (in_data.kind == wcv_pkg::KIND_PIXEL);
    assign is_flush = accept && (in_data.kind == wcv_pkg::KIND_FLUSH) && drain_reg;
    assign is_coef  = accept && (in_data.kind == wcv_pkg::KIND_COEF)
                      && (int'(in_data.coef_index) < wcv_pkg::NUM_TAPS);
    assign origin_clr = is_pix && (in_row_reg == '0) && (in_col_reg == '0);

    // emission decision and output position
    always_comb
    begin
        em_col_c  = origin_clr ? '0 : out_col_reg;
        em_row_c  = origin_clr ? '0 : out_row_reg;
        em_slot_c = origin_clr ? '0 : out_slot_reg;
        pend_base = origin_clr ? '0 : pend_reg;
        emit      = is_flush || (is_pix && ((pend_base + wcv_pkg::PEND_W'(1)) > lag));

        win_c = (wcv_pkg::EH_W'(em_row_c) >= wcv_pkg::EH_W'(half))
             && ((wcv_pkg::EH_W'(em_row_c) + wcv_pkg::EH_W'(half)) < eff_h)
             && (wcv_pkg::EW_W'(em_col_c) >= wcv_pkg::EW_W'(half))
             && ((wcv_pkg::EW_W'(em_col_c) + wcv_pkg::EW_W'(half)) < eff_w);
        last_c = (wcv_pkg::EH_W'(em_row_c) == eff_h - wcv_pkg::EH_W'(1))
              && (wcv_pkg::EW_W'(em_col_c) == eff_w - wcv_pkg::EW_W'(1));

        base_sum = {1'b0, em_slot_c} + (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL)
                   - (wcv_pkg::SLOT_W + 1)'(half);
        if (base_sum >= (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL))
        begin
            em_base_c = wcv_pkg::SLOT_W'(base_sum
                        - (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL));
        end
        else
        begin
            em_base_c = wcv_pkg::SLOT_W'(base_sum);
        end
    end

    // input and output position counters
    always_comb
    begin
        icol_inc  = wcv_pkg::EW_W'(in_col_reg) + wcv_pkg::EW_W'(1);
        irow_inc  = wcv_pkg::EH_W'(in_row_reg) + wcv_pkg::EH_W'(1);
        icol_wrap = icol_inc >= eff_w;
        irow_wrap = irow_inc >= eff_h;
        ocol_inc  = wcv_pkg::EW_W'(em_col_c) + wcv_pkg::EW_W'(1);
        orow_inc  = wcv_pkg::EH_W'(em_row_c) + wcv_pkg::EH_W'(1);
        ocol_wrap = ocol_inc >= eff_w;
        orow_wrap = orow_inc >= eff_h;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        pend_next  = pend_reg;
        drain_next = drain_reg;

        if (is_pix)
        begin
            pend_next = pend_base + wcv_pkg::PEND_W'(1);
            out_col_next  = em_col_c;
            out_row_next  = em_row_c;
            out_slot_next = em_slot_c;
            if (origin_clr)
            begin
                drain_next = 1'b0;
            end
            if (icol_wrap)
            begin
                in_col_next = '0;
                if (irow_wrap)
                begin
                    in_row_next  = '0;
                    in_slot_next = '0;
                    drain_next   = 1'b1;
                end
                else
                begin
                    in_row_next  = wcv_pkg::ROW_W'(irow_inc);
                    in_slot_next = (int'(in_slot_reg) == wcv_pkg::MAX_KERNEL - 1) ? '0
                                   : in_slot_reg + wcv_pkg::SLOT_W'(1);
                end
            end
            else
            begin
                in_col_next = wcv_pkg::COL_W'(icol_inc);
            end
        end

        if (emit)
        begin
            pend_next = pend_next - wcv_pkg::PEND_W'(1);
            if (ocol_wrap)
            begin
                out_col_next = '0;
                if (orow_wrap)
                begin
                    out_row_next  = '0;
                    out_slot_next = '0;
                    drain_next    = 1'b0;
                end
                else
                begin
                    out_row_next  = wcv_pkg::ROW_W'(orow_inc);
                    out_slot_next = (int'(em_slot_c) == wcv_pkg::MAX_KERNEL - 1) ? '0
                                    : em_slot_c + wcv_pkg::SLOT_W'(1);
                end
            end
            else
            begin
                out_col_next = wcv_pkg::COL_W'(ocol_inc);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wcv_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = win_c ? wcv_pkg::ST_CALC : wcv_pkg::ST_PASS;
                end
            end
            wcv_pkg::ST_PASS:
            begin
                state_next = wcv_pkg::ST_DONE;
            end
            wcv_pkg::ST_CALC:
            begin
                if (step_reg == wcv_pkg::STEP_W'(eff_k) + wcv_pkg::STEP_W'(1))
                begin
                    state_next = wcv_pkg::ST_CHAIN;
                end
            end
            wcv_pkg::ST_CHAIN:
            begin
                if (int'(step_reg) == wcv_pkg::MAX_KERNEL - 1)
                begin
                    state_next = wcv_pkg::ST_DONE;
                end
            end
            wcv_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = wcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wcv_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs and cell control
    always_comb
    begin
        in_ready       = 1'b0;
        load_out       = 1'b0;
        ctrl.pix_we    = is_pix;
        ctrl.wslot     = in_slot_reg;
        ctrl.pix_waddr = in_col_reg;
        ctrl.pix_wdata = in_data.pixel;
        ctrl.tap_we    = is_coef;
        ctrl.tap_waddr = wcv_pkg::TAP_AW'(in_data.coef_index);
        ctrl.tap_wdata = in_data.coef_value;
        ctrl.pix_re    = 1'b0;
        ctrl.issue     = 1'b0;
        ctrl.pix_raddr = em_col_reg - wcv_pkg::COL_W'(half) + wcv_pkg::COL_W'(step_reg);
        ctrl.col_j     = wcv_pkg::K_W'(step_reg);
        ctrl.base      = em_base_reg;
        ctrl.ksize     = eff_k;
        ctrl.acc_clr   = 1'b0;
        ctrl.chain_en  = 1'b0;
        case (state_reg)
            wcv_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            wcv_pkg::ST_PASS:
            begin
                ctrl.pix_re    = 1'b1;
                ctrl.pix_raddr = em_col_reg;
            end
            wcv_pkg::ST_CALC:
            begin
                ctrl.issue  = step_reg < wcv_pkg::STEP_W'(eff_k);
                ctrl.pix_re = ctrl.issue;
            end
            wcv_pkg::ST_CHAIN:
            begin
                ctrl.chain_en = 1'b1;
            end
            wcv_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // row of cells, partial sums ripple from slot 0 to the last slot
    for (genvar s = 0; s < wcv_pkg::MAX_KERNEL; s++)
    begin : g_cell
        logic signed [wcv_pkg::ACC_W-1:0] chain_prev;
        if (s == 0)
        begin : g_first
            assign chain_prev = '0;
        end
        else
        begin : g_next
            assign chain_prev = chain_w[s-1];
        end
        wcv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot      (wcv_pkg::SLOT_W'(s)),
            .ctrl      (ctrl),
            .tap_valid (tap_valid_reg),
            .chain_in  (chain_prev),
            .chain_out (chain_w[s]),
            .pix_rdata (pix_w[s])
        );
    end

    // rounding half up and saturation of the window sum
    always_comb
    begin
        rnd_sum = chain_w[wcv_pkg::MAX_KERNEL-1] + RND_HALF;
        shifted = rnd_sum >>> wcv_pkg::FRAC_BITS;
        if (shifted > PIX_MAX)
        begin
            sat_val = PIX_MAX;
        end
        else if (shifted < PIX_MIN)
        begin
            sat_val = PIX_MIN;
        end
        else
        begin
            sat_val = shifted;
        end
        result_c = em_win_reg ? sat_val[wcv_pkg::PIXEL_BITS-1:0] : pix_w[em_slot_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wcv_pkg::ST_IDLE;
            step_reg      <= '0;
            width_reg     <= wcv_pkg::CFG_WID_W'(1024);
            height_reg    <= wcv_pkg::CFG_HGT_W'(480);
            ksize_reg     <= wcv_pkg::CFG_KER_W'(7);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            pend_reg      <= '0;
            drain_reg     <= 1'b0;
            tap_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + wcv_pkg::STEP_W'(1);

            if (cfg_write && (cfg_index == wcv_pkg::CFG_IMAGE_WIDTH
                              || cfg_index == wcv_pkg::CFG_IMAGE_HEIGHT
                              || cfg_index == wcv_pkg::CFG_KERNEL_SIZE))
            begin
                if (cfg_index == wcv_pkg::CFG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data[wcv_pkg::CFG_WID_W-1:0];
                end
                if (cfg_index == wcv_pkg::CFG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg_data[wcv_pkg::CFG_HGT_W-1:0];
                end
                if (cfg_index == wcv_pkg::CFG_KERNEL_SIZE)
                begin
                    ksize_reg <= cfg_data[wcv_pkg::CFG_KER_W-1:0];
                end
                // restart the stream
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
                pend_reg     <= '0;
                drain_reg    <= 1'b0;
            end
            else
            begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                in_slot_reg  <= in_slot_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                out_slot_reg <= out_slot_next;
                pend_reg     <= pend_next;
                drain_reg    <= drain_next;
            end

            if (is_coef)
            begin
                tap_valid_reg[wcv_pkg::TAP_AW'(in_data.coef_index)] <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured position of the pixel being produced, and output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            em_col_reg  <= em_col_c;
            em_row_reg  <= em_row_c;
            em_slot_reg <= em_slot_c;
            em_base_reg <= em_base_c;
            em_win_reg  <= win_c;
            em_last_reg <= last_c;
        end
        if (load_out)
        begin
            out_data_reg.result_pixel <= result_c;
            out_data_reg.out_row      <= em_row_reg;
            out_data_reg.out_col      <= em_col_reg;
            out_data_reg.out_last     <= em_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // chain phase never runs past the cell count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wcv_pkg::ST_CHAIN |-> int'(step_reg) < wcv_pkg::MAX_KERNEL)
        else $error("chain phase overran the cell row");

    // a flush that emits always has a pending output
    assert property (@(posedge clk) disable iff (!rst_n)
        is_flush |-> pend_reg != '0)
        else $error("flush emitted with nothing pending");

    // a new result appears only after the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == wcv_pkg::ST_DONE)
        else $error("output valid raised outside done state");

    // compute phases are entered only with an emission captured
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wcv_pkg::ST_IDLE && state_next != wcv_pkg::ST_IDLE) |-> emit)
        else $error("left idle without an emission");

endmodule

>>> rtl/wcv_ram.sv
// generic simple dual-port ram with registered read
module wcv_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, holds data while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wcv_cell.sv
// one line-store slot with its tap copy, multiply-accumulate and partial-sum chain stage
module wcv_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [wcv_pkg::SLOT_W-1:0]       slot,
    input  wcv_pkg::cell_ctrl_t              ctrl,
    input  logic [wcv_pkg::NUM_TAPS-1:0]     tap_valid,
    input  logic signed [wcv_pkg::ACC_W-1:0] chain_in,
    output logic signed [wcv_pkg::ACC_W-1:0] chain_out,
    output logic signed [wcv_pkg::PIXEL_BITS-1:0] pix_rdata
);

    logic [wcv_pkg::SLOT_W:0]              row_sum;
    logic [wcv_pkg::SLOT_W-1:0]            krow;
    logic                                  active;
    logic [wcv_pkg::TAP_AW-1:0]            taddr;
    logic                                  line_we;
    logic [wcv_pkg::PIXEL_BITS-1:0]        pix_raw;
    logic [wcv_pkg::COEF_BITS-1:0]         tap_raw;
    logic signed [wcv_pkg::PIXEL_BITS-1:0] pix_s;
    logic signed [wcv_pkg::COEF_BITS-1:0]  tap_s;
    logic signed [wcv_pkg::PROD_W-1:0]     prod_next;
    logic signed [wcv_pkg::PROD_W-1:0]     prod_reg;
    logic                                  prod_vld_reg;
    logic                                  act_d_reg;
    logic                                  tvld_d_reg;
    logic signed [wcv_pkg::ACC_W-1:0]      acc_reg;
    logic signed [wcv_pkg::ACC_W-1:0]      acc_next;
    logic signed [wcv_pkg::ACC_W-1:0]      chain_reg;
    logic signed [wcv_pkg::ACC_W-1:0]      chain_next;

    // kernel row served by this slot for the current window
    always_comb
    begin
        row_sum = {1'b0, slot} + (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL)
                  - {1'b0, ctrl.base};
        if (row_sum >= (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL))
        begin
            krow = wcv_pkg::SLOT_W'(row_sum - (wcv_pkg::SLOT_W + 1)'(wcv_pkg::MAX_KERNEL));
        end
        else
        begin
            krow = wcv_pkg::SLOT_W'(row_sum);
        end
        active = (wcv_pkg::K_W + 1)'(krow) < (wcv_pkg::K_W + 1)'(ctrl.ksize);
        taddr  = wcv_pkg::TAP_AW'(krow) * wcv_pkg::TAP_AW'(ctrl.ksize)
                 + wcv_pkg::TAP_AW'(ctrl.col_j);
    end

    assign line_we = ctrl.pix_we && (ctrl.wslot == slot);

    // line store slot
    wcv_ram #(
        .WIDTH (wcv_pkg::PIXEL_BITS),
        .DEPTH (wcv_pkg::MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (ctrl.pix_waddr),
        .wdata (ctrl.pix_wdata),
        .re    (ctrl.pix_re),
        .raddr (ctrl.pix_raddr),
        .rdata (pix_raw)
    );

    // local copy of the taps
    wcv_ram #(
        .WIDTH (wcv_pkg::COEF_BITS),
        .DEPTH (wcv_pkg::NUM_TAPS)
    ) u_taps (
        .clk   (clk),
        .we    (ctrl.tap_we),
        .waddr (ctrl.tap_waddr),
        .wdata (ctrl.tap_wdata),
        .re    (ctrl.issue && active),
        .raddr (taddr),
        .rdata (tap_raw)
    );

    // product of read pixel and tap, unwritten taps read as zero
    always_comb
    begin
        pix_s     = signed'(pix_raw);
        tap_s     = tvld_d_reg ? signed'(tap_raw) : '0;
        prod_next = pix_s * tap_s;
        acc_next  = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + wcv_pkg::ACC_W'(prod_reg);
        end
        chain_next = acc_reg + chain_in;
    end

    // pipeline control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_d_reg    <= 1'b0;
            tvld_d_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            act_d_reg    <= ctrl.issue && active;
            tvld_d_reg   <= ctrl.issue && active && tap_valid[taddr];
            prod_vld_reg <= act_d_reg;
        end
    end

    // product, accumulator and chain registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.chain_en)
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;
    assign pix_rdata = signed'(pix_raw);

endmodule

>>> tb/sv/tb_window_convolution_2d.sv
// self-checking testbench of the streaming 2d window convolution block
`timescale 1ns / 100ps

module tb_window_convolution_2d;

    localparam int  LINE_DEPTH  = wcv_pkg::MAX_KERNEL * wcv_pkg::MAX_WIDTH;
    localparam int  SETTLE      = 3 * wcv_pkg::MAX_KERNEL + 20;
    localparam int  RANDOM_ITEMS = 800;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int  IN_BITS     = $bits(wcv_pkg::in_item_t);
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    wcv_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    wcv_pkg::out_item_t out_data;
    logic      cfg_write;
    logic [wcv_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wcv_pkg::CFG_DATA_W-1:0] cfg_data;

    window_convolution_2d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the filter state
    logic signed [wcv_pkg::PIXEL_BITS-1:0] row_mem [0:LINE_DEPTH-1];
    logic signed [wcv_pkg::COEF_BITS-1:0]  tap_mem [0:wcv_pkg::NUM_TAPS-1];
    int unsigned in_r, in_c, out_r, out_c;
    bit          draining;
    int unsigned reg_width, reg_height, reg_kernel;
    wcv_pkg::out_item_t filtered_q[$];
    int          error_count;
    int          items_done;
    bit          send_quiet;
    bit          ready_quiet;
    longint      cycles;
    int          stall_left;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        if (reg_width == 0)
            return 1;
        return (reg_width > wcv_pkg::MAX_WIDTH) ? wcv_pkg::MAX_WIDTH : reg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (reg_height == 0)
            return 1;
        return (reg_height > wcv_pkg::MAX_HEIGHT) ? wcv_pkg::MAX_HEIGHT : reg_height;
    endfunction

    function automatic int unsigned eff_kernel();
        int unsigned k;
        k = reg_kernel & 7;
        if (k == 0)
            k = 1;
        if ((k & 1) == 0)
            k = k - 1;
        if (k > wcv_pkg::KERN_TOP)
            k = wcv_pkg::KERN_TOP;
        return k;
    endfunction

    // filtered or passed-through value of output pixel (r, c)
    function automatic logic signed [wcv_pkg::PIXEL_BITS-1:0] window_sum(int unsigned r,
                                                                         int unsigned c);
        int unsigned w, hg, k, h, slot;
        longint acc, v;
        w = eff_width();
        hg = eff_height();
        k = eff_kernel();
        h = k / 2;
        if (!(r >= h && r + h < hg && c >= h && c + h < w))
            return row_mem[(r % wcv_pkg::MAX_KERNEL) * wcv_pkg::MAX_WIDTH + c];
        acc = 0;
        for (int i = 0; i < k; i++)
        begin
            slot = (r - h + i) % wcv_pkg::MAX_KERNEL;
            for (int j = 0; j < k; j++)
                acc += longint'(row_mem[slot * wcv_pkg::MAX_WIDTH + c - h + j])
                       * longint'(tap_mem[i * k + j]);
        end
        v = (acc + (longint'(1) << (wcv_pkg::FRAC_BITS - 1))) >>> wcv_pkg::FRAC_BITS;
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v[wcv_pkg::PIXEL_BITS-1:0];
    endfunction

    function automatic void emit_pixel();
        wcv_pkg::out_item_t e;
        int unsigned w, hg;
        w = eff_width();
        hg = eff_height();
        e.result_pixel = window_sum(out_r, out_c);
        e.out_row = out_r[11:0];
        e.out_col = out_c[9:0];
        e.out_last = (out_r == hg - 1 && out_c == w - 1);
        filtered_q.insert(filtered_q.size(), e);
        out_c++;
        if (out_c >= w)
        begin
            out_c = 0;
            out_r++;
            if (out_r >= hg)
            begin
                out_r = 0;
                draining = 1'b0;
            end
        end
    endfunction

    function automatic void restart_stream();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
        draining = 1'b0;
    endfunction

    // expected effect of one accepted transaction
    function automatic void filter_item(wcv_pkg::in_item_t it);
        int unsigned w, hg, h;
        longint n, o, lag;
        if (it.kind != KIND_UNUSED)
            items_done++;
        if (it.kind == wcv_pkg::KIND_COEF)
        begin
            if (it.coef_index < wcv_pkg::NUM_TAPS)
                tap_mem[it.coef_index] = it.coef_value;
        end
        else if (it.kind == wcv_pkg::KIND_PIXEL)
        begin
            w = eff_width();
            hg = eff_height();
            h = eff_kernel() / 2;
            if (in_r == 0 && in_c == 0)
            begin
                out_r = 0;
                out_c = 0;
                draining = 1'b0;
            end
            row_mem[(in_r % wcv_pkg::MAX_KERNEL) * wcv_pkg::MAX_WIDTH + in_c] = it.pixel;
            n = longint'(in_r) * w + in_c;
            in_c++;
            if (in_c >= w)
            begin
                in_c = 0;
                in_r++;
                if (in_r >= hg)
                begin
                    in_r = 0;
                    draining = 1'b1;
                end
            end
            o = longint'(out_r) * w + out_c;
            lag = longint'(h) * w + h;
            if (n >= o + lag)
                emit_pixel();
        end
        else if (it.kind == wcv_pkg::KIND_FLUSH && draining)
            emit_pixel();
    endfunction

    // result checker
    always @(posedge clk)
    begin
        wcv_pkg::out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("result transaction with none expected: pixel %0d row %0d col %0d",
                       out_data.result_pixel, out_data.out_row, out_data.out_col);
                error_count++;
            end
            else
            begin
                e = filtered_q.pop_front();
                if (out_data.result_pixel !== e.result_pixel)
                begin
                    $error("result_pixel expected %0d actual %0d", e.result_pixel,
                           out_data.result_pixel);
                    error_count++;
                end
                if (out_data.out_row !== e.out_row)
                begin
                    $error("out_row expected %0d actual %0d", e.out_row, out_data.out_row);
                    error_count++;
                end
                if (out_data.out_col !== e.out_col)
                begin
                    $error("out_col expected %0d actual %0d", e.out_col, out_data.out_col);
                    error_count++;
                end
                if (out_data.out_last !== e.out_last)
                begin
                    $error("out_last expected %0d actual %0d", e.out_last, out_data.out_last);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (!ready_quiet && r < 25)
                stall_left = (r < 22) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        if (send_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic wcv_pkg::in_item_t make_item(logic [1:0] kind);
        wcv_pkg::in_item_t it;
        it = wcv_pkg::in_item_t'(IN_BITS'({$urandom, $urandom}));
        it.kind = kind;
        return it;
    endfunction

    task automatic send_item(wcv_pkg::in_item_t it);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        filter_item(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_pixel(logic signed [wcv_pkg::PIXEL_BITS-1:0] value);
        wcv_pkg::in_item_t it;
        it = make_item(wcv_pkg::KIND_PIXEL);
        it.pixel = value;
        send_item(it);
    endtask

    task automatic send_tap(int idx, logic signed [wcv_pkg::COEF_BITS-1:0] value);
        wcv_pkg::in_item_t it;
        it = make_item(wcv_pkg::KIND_COEF);
        it.coef_index = idx[5:0];
        it.coef_value = value;
        send_item(it);
    endtask

    task automatic send_flush();
        send_item(make_item(wcv_pkg::KIND_FLUSH));
    endtask

    task automatic flush_pending();
        while (draining)
            send_flush();
    endtask

    // stop sending and wait for every expected result
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic [wcv_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        wait_results();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[wcv_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            wcv_pkg::CFG_IMAGE_WIDTH:  reg_width = value & 12'h7FF;
            wcv_pkg::CFG_IMAGE_HEIGHT: reg_height = value & 16'h1FFF;
            wcv_pkg::CFG_KERNEL_SIZE:  reg_kernel = value & 7;
            default: ;
        endcase
        restart_stream();
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned k);
        write_reg(wcv_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(wcv_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(wcv_pkg::CFG_KERNEL_SIZE, k);
    endtask

    // tap extremes, ignored items, one small saturating image
    task automatic test_directed();
        set_geometry(3, 3, 3);
        send_tap(0, -16'sd32768);
        for (int i = 1; i < 9; i++)
            send_tap(i, 16'sd32767);
        send_tap(63, 16'sd1234);
        send_item(make_item(KIND_UNUSED));
        send_flush();
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 12'sd2047 : -12'sd2048);
        flush_pending();
    endtask

    // register extremes and out-of-range encodings
    task automatic test_config_extremes();
        // widest row, kernel of one, partly sent: every pixel is emitted as soon as it arrives
        set_geometry(1024, 1, 1);
        for (int i = 0; i < 48; i++)
            send_pixel(12'($urandom));
        flush_pending();
        // tallest image, partly sent, then abandoned by the next write
        set_geometry(1, 4096, 7);
        for (int i = 0; i < 40; i++)
            send_pixel(12'($urandom));
        // zero and oversized encodings
        set_geometry(0, 0, 0);
        send_pixel(12'sd5);
        flush_pending();
        set_geometry(2047, 8191, 6);
        for (int i = 0; i < 30; i++)
            send_pixel(12'($urandom));
        set_geometry(5, 5, 4);
        for (int i = 0; i < 9; i++)
            send_tap(i, -16'sd32768);
        for (int i = 0; i < 25; i++)
            send_pixel(12'sd2047);
        flush_pending();
        set_geometry(7, 7, 2);
        for (int i = 0; i < 49; i++)
            send_pixel(12'($urandom));
        flush_pending();
    endtask

    // a new image while the previous one still drains
    task automatic test_restart_mid_drain();
        set_geometry(6, 4, 5);
        for (int i = 0; i < 25; i++)
            send_tap(i, 16'($urandom_range(0, 8191)));
        for (int i = 0; i < 24; i++)
            send_pixel(12'($urandom));
        send_flush();
        send_flush();
        for (int i = 0; i < 24; i++)
            send_pixel(12'($urandom));
        flush_pending();
        send_flush();
    endtask

    // random geometries, taps and images
    task automatic test_random_stream();
        int unsigned w, h, k, npix, stop_at, r, nimg;
        int start_items;
        logic signed [wcv_pkg::PIXEL_BITS-1:0] p;
        start_items = items_done;
        while (items_done - start_items < RANDOM_ITEMS)
        begin
            send_quiet = ($urandom_range(0, 4) == 0);
            ready_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            w = (r < 80) ? $urandom_range(1, 12) : (r < 92) ? $urandom_range(13, 40) : 0;
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            k = $urandom_range(0, 7);
            set_geometry(w, h, k);
            repeat ($urandom_range(0, 49))
                send_tap($urandom_range(0, 63), 16'($urandom));
            nimg = $urandom_range(1, 3);
            for (int m = 0; m < nimg; m++)
            begin
                npix = eff_width() * eff_height();
                stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1) : npix;
                for (int i = 0; i < stop_at; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        send_item(make_item(KIND_UNUSED));
                    else if (r < 5)
                        send_tap($urandom_range(0, 63), 16'($urandom));
                    else if (r < 6)
                        send_flush();
                    if (r == 50)
                        wait_results();
                    r = $urandom_range(0, 19);
                    p = (r == 0) ? 12'sd2047 : (r == 1) ? -12'sd2048 : 12'($urandom);
                    send_pixel(p);
                end
                if (stop_at < npix)
                    break;
                r = $urandom_range(0, 9);
                if (r < 7)
                    flush_pending();
                else if (r < 9)
                    repeat ($urandom_range(0, 5))
                        send_flush();
            end
        end
        send_quiet = 1'b0;
        ready_quiet = 1'b0;
    endtask

    // sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        items_done = 0;
        send_quiet = 1'b0;
        ready_quiet = 1'b0;
        reg_width = 1024;
        reg_height = 480;
        reg_kernel = 7;
        for (int i = 0; i < wcv_pkg::NUM_TAPS; i++)
            tap_mem[i] = '0;
        restart_stream();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_restart_mid_drain();
        test_random_stream();

        wait_results();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
